/* src/ags_pkg.sv */
// ----------------------------------------------------------------------------
// ags_pkg
// Types, codes and sizes shared by the acyclic graph store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ags_pkg;

  localparam int NODE_SLOTS_DEF = 64;
  localparam int EDGE_SLOTS_DEF = 256;

  localparam logic [2:0] OP_ADD_NODE   = 3'd0;
  localparam logic [2:0] OP_ADD_EDGE   = 3'd1;
  localparam logic [2:0] OP_SET_FLAGS  = 3'd2;
  localparam logic [2:0] OP_CHECK_NODE = 3'd3;
  localparam logic [2:0] OP_CHECK_EDGE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ARG = 2'd1;
  localparam logic [1:0] ST_CYCLE   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [3:0] NODE_KIND_MAX = 4'd8;
  localparam logic [3:0] EDGE_KIND_MAX = 4'd7;
  localparam logic [7:0] FLAG_OPEN     = 8'h01;
  localparam logic [7:0] FLAG_CLOSED   = 8'h02;
  localparam logic [7:0] FLAG_KNOWN    = 8'h07;
  localparam logic [15:0] GEN_LIVE     = 16'd1;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  kind;
    logic [31:0] actor_num;
    logic [15:0] subject_index;
    logic [15:0] subject_generation;
    logic [15:0] target_index;
    logic [15:0] target_generation;
    logic [7:0]  flag_bits;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] new_index;
    logic       id_valid;
  } out_t;

endpackage

/* src/ags_ram.sv */
// ----------------------------------------------------------------------------
// ags_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ags_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/acyclic_graph_store_top.sv */
// ----------------------------------------------------------------------------
// acyclic_graph_store_top
// Bounded append-only DAG store with a depth-first cycle check on edge add.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one operation (in_data); out_valid/out_ready
//   carry its single result (out_data). One result per operation, in order.
//   Add node, set flags, checks and edges with bad arguments or a self-loop finish in the accept
//   cycle; the result is registered and shows in the next cycle.
//   Add edge with valid arguments first clears the visited RAM, one entry
//   per node in the store, then walks depth-first from the destination:
//   each popped node needs a stack read and a visited read and, for a node
//   not yet visited, one pass over the edge table, paced by the single edge
//   RAM read port and the visited read behind it.
//   One operation is in work at a time; in_ready is low during a walk and
//   while a finished result cannot be placed in the output register.
//   A stalled receiver holds out_data; the next item is still taken as long
//   as out_ready frees the register in the same cycle.
//   Reset clears the node and edge counts; tables are append-only and their
//   contents above the counts are never used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module acyclic_graph_store_top #(
  parameter int NODE_SLOTS = ags_pkg::NODE_SLOTS_DEF,
  parameter int EDGE_SLOTS = ags_pkg::EDGE_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ags_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ags_pkg::out_t out_data
);
  import ags_pkg::*;

  localparam int NW = $clog2(NODE_SLOTS);
  localparam int EW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_POPW = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_VIS  = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [NW:0]           node_total_r, node_total_nxt;
  logic [EW:0]           edge_total_r, edge_total_nxt;
  logic [NW:0]           depth_r, depth_nxt;
  logic [EW:0]           eidx_r, eidx_nxt;
  logic [NW:0]           clr_r, clr_nxt;
  logic                  pend_r, pend_nxt;
  logic                  hit_r, hit_nxt;
  logic                  reach_r, reach_nxt;
  logic [NW-1:0]         src_r, src_nxt, dst_r, dst_nxt, here_r, here_nxt;
  logic [NW-1:0]         cand_r, cand_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_r, out_nxt;

  logic                  in_fire, out_free;
  logic                  s_ok, t_ok, e_ok;
  logic                  stk_we, edg_we, vis_we;
  logic [NW-1:0]         stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic [EW-1:0]         edg_waddr, edg_raddr;
  logic [2*NW-1:0]       edg_wdata, edg_rdata;
  logic [NW-1:0]         vis_waddr, vis_raddr;
  logic                  vis_wdata, vis_rdata;
  logic [NW-1:0]         e_src, e_dst;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign s_ok = (32'(in_data.subject_index) < 32'(node_total_r)) &&
                (in_data.subject_generation == GEN_LIVE);
  assign t_ok = (32'(in_data.target_index) < 32'(node_total_r)) &&
                (in_data.target_generation == GEN_LIVE);
  assign e_ok = (32'(in_data.subject_index) < 32'(edge_total_r)) &&
                (in_data.subject_generation == GEN_LIVE);

  assign e_src = edg_rdata[2*NW-1:NW];
  assign e_dst = edg_rdata[NW-1:0];

  ags_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  ags_ram #(.WIDTH(2*NW), .DEPTH(EDGE_SLOTS)) u_edges (
    .clk(clk), .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
    .raddr(edg_raddr), .rdata(edg_rdata)
  );

  ags_ram #(.WIDTH(1), .DEPTH(NODE_SLOTS)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    node_total_nxt = node_total_r;
    edge_total_nxt = edge_total_r;
    depth_nxt      = depth_r;
    eidx_nxt       = eidx_r;
    clr_nxt        = clr_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    reach_nxt      = reach_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    here_nxt       = here_r;
    cand_nxt       = cand_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    stk_we         = 1'b0;
    stk_waddr      = depth_r[NW-1:0];
    stk_wdata      = dst_r;
    stk_raddr      = '0;
    edg_we         = 1'b0;
    edg_waddr      = edge_total_r[EW-1:0];
    edg_wdata      = {src_r, dst_r};
    edg_raddr      = eidx_r[EW-1:0];
    vis_we         = 1'b0;
    vis_waddr      = here_r;
    vis_wdata      = 1'b0;
    vis_raddr      = e_dst;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_OK, new_index: 8'd0, id_valid: 1'b0};
          case (in_data.op)
            OP_ADD_NODE: begin
              if (in_data.kind > NODE_KIND_MAX) begin
                out_nxt.status = ST_BAD_ARG;
              end else if (32'(node_total_r) >= 32'(NODE_SLOTS)) begin
                out_nxt.status = ST_FULL;
              end else begin
                out_nxt.new_index = 8'(node_total_r);
                node_total_nxt    = node_total_r + 1'b1;
              end
            end
            OP_ADD_EDGE: begin
              if (in_data.kind > EDGE_KIND_MAX || !s_ok || !t_ok) begin
                out_nxt.status = ST_BAD_ARG;
              end else if (in_data.subject_index == in_data.target_index) begin
                out_nxt.status = ST_CYCLE;
              end else begin
                out_valid_nxt = out_valid_r && !out_ready;
                out_nxt       = out_r;
                src_nxt       = in_data.subject_index[NW-1:0];
                dst_nxt       = in_data.target_index[NW-1:0];
                stk_we        = 1'b1;
                stk_waddr     = '0;
                stk_wdata     = in_data.target_index[NW-1:0];
                depth_nxt     = (NW+1)'(1);
                clr_nxt       = '0;
                state_nxt     = S_CLR;
              end
            end
            OP_SET_FLAGS: begin
              if (!s_ok || (in_data.flag_bits & ~FLAG_KNOWN) != 8'd0 ||
                  ((in_data.flag_bits & FLAG_OPEN) != 8'd0 &&
                   (in_data.flag_bits & FLAG_CLOSED) != 8'd0)) begin
                out_nxt.status = ST_BAD_ARG;
              end
            end
            OP_CHECK_NODE: out_nxt.id_valid = s_ok;
            OP_CHECK_EDGE: out_nxt.id_valid = e_ok;
            default:       out_nxt.status   = ST_BAD_ARG;
          endcase
        end
      end
      S_CLR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_r[NW-1:0];
        vis_wdata = 1'b0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r + 1'b1 == node_total_r) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (depth_r == '0) begin
          reach_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          stk_raddr = NW'(depth_r - 1'b1);
          depth_nxt = depth_r - 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        if (stk_rdata == src_r) begin
          reach_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          vis_raddr = stk_rdata;
          here_nxt  = stk_rdata;
          state_nxt = S_VIS;
        end
      end
      S_VIS: begin
        if (vis_rdata) begin
          state_nxt = S_POP;
        end else begin
          vis_we    = 1'b1;
          vis_waddr = here_r;
          vis_wdata = 1'b1;
          eidx_nxt  = '0;
          pend_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        pend_nxt = eidx_r < edge_total_r;
        if (eidx_r < edge_total_r) begin
          eidx_nxt = eidx_r + 1'b1;
        end
        hit_nxt  = pend_r && e_src == here_r;
        cand_nxt = e_dst;
        if (hit_r && !vis_rdata) begin
          if (32'(depth_r) >= 32'(NODE_SLOTS)) begin
            reach_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            stk_we    = 1'b1;
            stk_wdata = cand_r;
            depth_nxt = depth_r + 1'b1;
          end
        end
        if (!pend_r && !hit_r && !(eidx_r < edge_total_r)) begin
          state_nxt = S_POP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_OK, new_index: 8'd0, id_valid: 1'b0};
          if (reach_r) begin
            out_nxt.status = ST_CYCLE;
          end else if (32'(edge_total_r) >= 32'(EDGE_SLOTS)) begin
            out_nxt.status = ST_FULL;
          end else begin
            edg_we            = 1'b1;
            out_nxt.new_index = 8'(edge_total_r);
            edge_total_nxt    = edge_total_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_total_r <= '0;
      edge_total_r <= '0;
      depth_r      <= '0;
      eidx_r       <= '0;
      clr_r        <= '0;
      pend_r       <= 1'b0;
      hit_r        <= 1'b0;
      reach_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_total_r <= node_total_nxt;
      edge_total_r <= edge_total_nxt;
      depth_r      <= depth_nxt;
      eidx_r       <= eidx_nxt;
      clr_r        <= clr_nxt;
      pend_r       <= pend_nxt;
      hit_r        <= hit_nxt;
      reach_r      <= reach_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    here_r <= here_nxt;
    cand_r <= cand_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= 32'(NODE_SLOTS)) else $error("walk stack over depth");
  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(node_total_r) <= 32'(NODE_SLOTS)) else $error("node count over limit");
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(edge_total_r) <= 32'(EDGE_SLOTS)) else $error("edge count over limit");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_walk_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(edge_total_r)) else $error("edge add mid walk");
`endif
endmodule
